// ----- src/caq_pkg.sv -----
// ----------------------------------------------------------------------------
// caq_pkg: shared constants for the coalescing action queue
// Request codes, insert status codes and the fixed field widths.
// ----------------------------------------------------------------------------
package caq_pkg;

    // Fixed field widths.
    localparam int REQ_W    = 3;
    localparam int PARAM_W  = 8;
    localparam int TRACK_W  = 8;
    localparam int STATUS_W = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REWIND  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 3'd4;

    // Insert status codes.
    localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // Status value reported for every request that is not an insert.
    localparam logic [STATUS_W-1:0] ST_NONE = ST_APPENDED;

endpackage

// ----- src/coalescing_action_queue.sv -----
// ----------------------------------------------------------------------------
// coalescing_action_queue: table of pending actions with merging
// Inserts merge into an entry with the same action and track, or append a
// new one if the table has room; a separate read index walks the table.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one response per
// request. For clear, rewind, advance and unknown request codes the response
// passes from the result registers into the output register; a read first
// waits for the registered RAM read data. An insert scans the filled entries
// through the single read port of the entry RAM, one entry per cycle, and
// stops at the first entry whose action and track match. A new request is
// accepted from the cycle after the previous response has moved into the
// output register, even while that response still waits to be taken.
// Entry contents live in one RAM; per-entry valid bits, cleared by reset,
// make unwritten entries read as zero, and a clear drops only the action
// valid bits, so a cleared entry reads as no-action with its old parameter
// and track.
// ----------------------------------------------------------------------------
module coalescing_action_queue #(
    parameter int DEPTH       = 16,
    parameter int ACTION_BITS = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [caq_pkg::REQ_W-1:0]     req_type,
    input  logic [ACTION_BITS-1:0]        action_code,
    input  logic [caq_pkg::PARAM_W-1:0]   action_param,
    input  logic [caq_pkg::TRACK_W-1:0]   track_number,

    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [ACTION_BITS-1:0]        entry_action,
    output logic [caq_pkg::PARAM_W-1:0]   entry_param,
    output logic [caq_pkg::TRACK_W-1:0]   entry_track,
    output logic                          in_range,
    output logic [caq_pkg::STATUS_W-1:0]  insert_status
);

    import caq_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int RI_W   = $clog2(DEPTH + 1);
    localparam int WORD_W = ACTION_BITS + TRACK_W + PARAM_W;

    localparam logic [RI_W-1:0]  RI_END   = RI_W'(DEPTH);
    localparam logic [IDX_W-1:0] FILL_MAX = IDX_W'(DEPTH - 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_RDW  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]          state_reg,      state_next;
    logic [IDX_W-1:0]    fill_count_reg, fill_count_next;
    logic [RI_W-1:0]     read_index_reg, read_index_next;
    logic [IDX_W-1:0]    ins_idx_reg,    ins_idx_next;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                cmp_vld_reg,    cmp_vld_next;
    logic [DEPTH-1:0]    act_vld_reg,    act_vld_next;
    logic [DEPTH-1:0]    pt_vld_reg,     pt_vld_next;
    logic                rd_act_vld_reg;
    logic                rd_pt_vld_reg;

    // Request key held for the duration of an insert.
    logic [ACTION_BITS-1:0] key_action_reg, key_action_next;
    logic [PARAM_W-1:0]     key_param_reg,  key_param_next;
    logic [TRACK_W-1:0]     key_track_reg,  key_track_next;

    // Finished response waiting for the output register.
    logic [ACTION_BITS-1:0] res_action_reg, res_action_next;
    logic [PARAM_W-1:0]     res_param_reg,  res_param_next;
    logic [TRACK_W-1:0]     res_track_reg,  res_track_next;
    logic                   res_rng_reg,    res_rng_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;

    // Output register.
    logic                   rsp_valid_reg;
    logic [ACTION_BITS-1:0] rsp_action_reg;
    logic [PARAM_W-1:0]     rsp_param_reg;
    logic [TRACK_W-1:0]     rsp_track_reg;
    logic                   rsp_rng_reg;
    logic [STATUS_W-1:0]    rsp_status_reg;
    logic                   rsp_load;

    // Entry RAM ports.
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    // Entry fields as seen through the valid bits.
    logic [ACTION_BITS-1:0] eff_action;
    logic [PARAM_W-1:0]     eff_param;
    logic [TRACK_W-1:0]     eff_track;
    logic                   cmp_hit;
    logic [RI_W-1:0]        ri_inc;

    caq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The RAM word is {action, track, param}. An entry whose action was
    // cleared reads as no-action; an entry never written reads as all zero.
    assign eff_action = rd_act_vld_reg ? ram_rdata[WORD_W-1 -: ACTION_BITS]
                                       : '0;
    assign eff_track  = rd_pt_vld_reg ? ram_rdata[PARAM_W +: TRACK_W] : '0;
    assign eff_param  = rd_pt_vld_reg ? ram_rdata[PARAM_W-1:0] : '0;
    assign cmp_hit    = (eff_action == key_action_reg) &&
                        (eff_track == key_track_reg);
    assign ri_inc     = read_index_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        read_index_next = read_index_reg;
        ins_idx_next    = ins_idx_reg;
        cmp_vld_next    = 1'b0;
        act_vld_next    = act_vld_reg;
        pt_vld_next     = pt_vld_reg;
        key_action_next = key_action_reg;
        key_param_next  = key_param_reg;
        key_track_next  = key_track_reg;
        res_action_next = res_action_reg;
        res_param_next  = res_param_reg;
        res_track_next  = res_track_reg;
        res_rng_next    = res_rng_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = fill_count_reg;
        ram_wdata       = {key_action_reg, key_track_reg, key_param_reg};
        ram_raddr       = read_index_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_action_next = action_code;
                    key_param_next  = action_param;
                    key_track_next  = track_number;
                    res_action_next = '0;
                    res_param_next  = '0;
                    res_track_next  = '0;
                    res_rng_next    = 1'b0;
                    res_status_next = ST_NONE;
                    state_next      = S_OUT;
                    unique case (req_type)
                        REQ_CLEAR:
                        begin
                            fill_count_next = '0;
                            read_index_next = '0;
                            act_vld_next    = '0;
                        end
                        REQ_INSERT:
                        begin
                            ins_idx_next = '0;
                            state_next   = S_SRCH;
                        end
                        REQ_REWIND:
                        begin
                            read_index_next = '0;
                        end
                        REQ_READ:
                        begin
                            // The RAM is already addressed by the read index.
                            if (read_index_reg != RI_END)
                            begin
                                state_next = S_RDW;
                            end
                        end
                        REQ_ADVANCE:
                        begin
                            if (read_index_reg != RI_END)
                            begin
                                read_index_next = ri_inc;
                                res_rng_next    = (ri_inc != RI_END);
                            end
                        end
                        default:
                        begin
                            // Unknown request: no state change, zero response.
                        end
                    endcase
                end
            end

            S_SRCH:
            begin
                // One read issued per cycle; the compare works on the entry
                // read in the cycle before.
                ram_raddr = ins_idx_reg;
                if (cmp_vld_reg && cmp_hit)
                begin
                    ram_we                    = 1'b1;
                    ram_waddr                 = cmp_idx_reg;
                    act_vld_next[cmp_idx_reg] = 1'b1;
                    pt_vld_next[cmp_idx_reg]  = 1'b1;
                    res_status_next           = ST_MERGED;
                    state_next                = S_OUT;
                end
                else if (ins_idx_reg == fill_count_reg)
                begin
                    if (fill_count_reg == FILL_MAX)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we                       = 1'b1;
                        act_vld_next[fill_count_reg] = 1'b1;
                        pt_vld_next[fill_count_reg]  = 1'b1;
                        fill_count_next              = fill_count_reg + 1'b1;
                        res_status_next              = ST_APPENDED;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    ins_idx_next = ins_idx_reg + 1'b1;
                end
            end

            S_RDW:
            begin
                res_action_next = eff_action;
                res_param_next  = eff_param;
                res_track_next  = eff_track;
                res_rng_next    = 1'b1;
                state_next      = S_OUT;
            end

            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_load = (state_reg == S_OUT) && (!rsp_valid_reg || rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_count_reg <= '0;
            read_index_reg <= '0;
            ins_idx_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            act_vld_reg    <= '0;
            pt_vld_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            read_index_reg <= read_index_next;
            ins_idx_reg    <= ins_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            act_vld_reg    <= act_vld_next;
            pt_vld_reg     <= pt_vld_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers; the valid bits are looked up alongside the RAM read
    // so that they line up with the read data.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= ins_idx_reg;
        rd_act_vld_reg <= act_vld_reg[ram_raddr];
        rd_pt_vld_reg  <= pt_vld_reg[ram_raddr];
        key_action_reg <= key_action_next;
        key_param_reg  <= key_param_next;
        key_track_reg  <= key_track_next;
        res_action_reg <= res_action_next;
        res_param_reg  <= res_param_next;
        res_track_reg  <= res_track_next;
        res_rng_reg    <= res_rng_next;
        res_status_reg <= res_status_next;
        if (rsp_load)
        begin
            rsp_action_reg <= res_action_reg;
            rsp_param_reg  <= res_param_reg;
            rsp_track_reg  <= res_track_reg;
            rsp_rng_reg    <= res_rng_reg;
            rsp_status_reg <= res_status_reg;
        end
    end

    assign req_ready     = (state_reg == S_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign entry_action  = rsp_action_reg;
    assign entry_param   = rsp_param_reg;
    assign entry_track   = rsp_track_reg;
    assign in_range      = rsp_rng_reg;
    assign insert_status = rsp_status_reg;

    // The table never holds more than DEPTH-1 entries.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_MAX)
        else $error("fill count beyond DEPTH-1");

    // The read index saturates at DEPTH.
    a_ri_bound: assert property (@(posedge clk) disable iff (!rst_n)
        read_index_reg <= RI_END)
        else $error("read index beyond DEPTH");

    // Every entry compared during a search lies below the fill count and
    // must have been written since the last clear.
    a_search_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) && cmp_vld_reg |-> rd_act_vld_reg && rd_pt_vld_reg)
        else $error("search compared an entry that was never filled");

    // Only one request is in the block at a time.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request accepted while one is in work");

    // A delivered status is always one of the defined codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_status_reg == ST_APPENDED) ||
                          (rsp_status_reg == ST_MERGED) ||
                          (rsp_status_reg == ST_FULL))
        else $error("undefined insert status");

endmodule

// ----- src/caq_ram.sv -----
// ----------------------------------------------------------------------------
// caq_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address. Contents are undefined until written.
// ----------------------------------------------------------------------------
module caq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sim/coalescing_action_queue_test.sv -----
// ----------------------------------------------------------------------------
// coalescing_action_queue_test: self-checking bench for the action queue
// Runs a short table of directed requests, then random episodes that fill
// the table, walk the read index off its end and mix in junk codes. Each
// response is compared field by field with a behavioral copy of the table.
// ----------------------------------------------------------------------------
module coalescing_action_queue_test;

    import caq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int ACTION_BITS = 3;

    // Request codes the block does not define. They must leave the table
    // alone and answer with an all-zero response.
    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

    localparam logic [ACTION_BITS-1:0] NO_ACTION  = '0;
    localparam logic [ACTION_BITS-1:0] ACTION_MAX = '1;
    localparam logic [PARAM_W-1:0]     PARAM_MAX  = '1;
    localparam logic [TRACK_W-1:0]     TRACK_MAX  = '1;

    // About 800 defined requests in all, directed ones included.
    localparam int TOTAL_REQUESTS = 800;

    // A correct block never goes this long without moving a request or a
    // response: the worst case is a long sender gap, a full-table insert
    // scan and a long receiver stall.
    localparam int IDLE_LIMIT = 2000;

    // Cycles to keep watching after the last response, so that a stray
    // extra response would still be caught.
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [REQ_W-1:0]       kind;
        logic [ACTION_BITS-1:0] action;
        logic [PARAM_W-1:0]     param;
        logic [TRACK_W-1:0]     track;
    } request_t;

    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [PARAM_W-1:0]     param;
        logic [TRACK_W-1:0]     track;
        logic                   in_range;
        logic [STATUS_W-1:0]    status;
    } response_t;

    // One row of the directed table. When known is set, the response was
    // written down by hand and is used instead of the predicted one.
    typedef struct packed {
        request_t  req;
        logic      known;
        response_t rsp;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [REQ_W-1:0]       req_type = '0;
    logic [ACTION_BITS-1:0] action_code = '0;
    logic [PARAM_W-1:0]     action_param = '0;
    logic [TRACK_W-1:0]     track_number = '0;

    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    logic [ACTION_BITS-1:0] entry_action;
    logic [PARAM_W-1:0]     entry_param;
    logic [TRACK_W-1:0]     entry_track;
    logic                   in_range;
    logic [STATUS_W-1:0]    insert_status;

    coalescing_action_queue #(
        .DEPTH       (DEPTH),
        .ACTION_BITS (ACTION_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .action_code   (action_code),
        .action_param  (action_param),
        .track_number  (track_number),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .entry_action  (entry_action),
        .entry_param   (entry_param),
        .entry_track   (entry_track),
        .in_range      (in_range),
        .insert_status (insert_status)
    );

    // ------------------------------------------------------------------------
    // Behavioral copy of the action table.
    // ------------------------------------------------------------------------
    logic [ACTION_BITS-1:0] slot_action [DEPTH];
    logic [PARAM_W-1:0]     slot_param  [DEPTH];
    logic [TRACK_W-1:0]     slot_track  [DEPTH];
    int                     fill_count;
    int                     read_index;

    // Responses still owed by the block, oldest first.
    response_t              awaited_responses [$];
    directed_row_t          directed_rows [$];

    int                     mismatches = 0;
    int                     requests_sent = 0;
    int                     idle_cycles = 0;
    int                     stall_left = 0;

    // While quiet is set neither side inserts gaps, so the block also sees
    // long back-to-back stretches.
    bit                     quiet = 1'b0;

    // Applies one request to the table copy and returns the response the
    // block should give for it.
    function automatic response_t apply_to_table(input request_t r);
        response_t rsp;
        bit        merged;
        rsp    = '0;
        merged = 1'b0;
        case (r.kind)
            REQ_CLEAR:
            begin
                // Only the actions are dropped; parameter and track of each
                // entry survive and can still be read back afterwards.
                fill_count = 0;
                read_index = 0;
                for (int i = 0; i < DEPTH; i++)
                begin
                    slot_action[i] = NO_ACTION;
                end
            end
            REQ_INSERT:
            begin
                // Search the filled entries from the bottom for the same
                // action and track; the first hit takes the new parameter.
                for (int i = 0; i < fill_count && !merged; i++)
                begin
                    if (slot_action[i] == r.action && slot_track[i] == r.track)
                    begin
                        slot_param[i] = r.param;
                        merged        = 1'b1;
                    end
                end
                if (merged)
                begin
                    rsp.status = ST_MERGED;
                end
                else if (fill_count < DEPTH - 1)
                begin
                    // One entry is always kept free, so the table holds at
                    // most DEPTH-1 actions.
                    slot_action[fill_count] = r.action;
                    slot_param[fill_count]  = r.param;
                    slot_track[fill_count]  = r.track;
                    fill_count++;
                    rsp.status = ST_APPENDED;
                end
                else
                begin
                    rsp.status = ST_FULL;
                end
            end
            REQ_REWIND:
            begin
                read_index = 0;
            end
            REQ_READ:
            begin
                // Reads ignore the fill count: stale and empty entries are
                // returned as they stand while the index is in range.
                if (read_index < DEPTH)
                begin
                    rsp.action   = slot_action[read_index];
                    rsp.param    = slot_param[read_index];
                    rsp.track    = slot_track[read_index];
                    rsp.in_range = 1'b1;
                end
            end
            REQ_ADVANCE:
            begin
                // The index stops at DEPTH; the flag tells where it landed.
                if (read_index < DEPTH)
                begin
                    read_index++;
                end
                rsp.in_range = (read_index < DEPTH);
            end
            default:
            begin
                // Undefined codes: nothing changes, all fields are zero.
            end
        endcase
        return rsp;
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Presents one request, holds it until the block takes it, and then
    // records the response it must produce. Valid is raised or dropped only
    // once per clock edge.
    task automatic send_request(input request_t r, input logic known,
                                input response_t known_rsp);
        int        gap;
        response_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        req_type     <= r.kind;
        action_code  <= r.action;
        action_param <= r.param;
        track_number <= r.track;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        predicted = apply_to_table(r);
        awaited_responses.push_back(known ? known_rsp : predicted);
        if (r.kind <= REQ_ADVANCE)
        begin
            requests_sent++;
        end
    endtask

    task automatic add_row(input logic [REQ_W-1:0] kind,
                           input logic [ACTION_BITS-1:0] action,
                           input logic [PARAM_W-1:0] param,
                           input logic [TRACK_W-1:0] track,
                           input logic known,
                           input response_t rsp);
        directed_row_t row;
        row.req.kind   = kind;
        row.req.action = action;
        row.req.param  = param;
        row.req.track  = track;
        row.known      = known;
        row.rsp        = rsp;
        directed_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset.
    // ------------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Response side: random stalls on rsp_ready, with ready raised again
    // in between two stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
            end
        end
    end

    // Every accepted response is matched against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_responses.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, got %0h %0h %0h %0h %0h",
                         $time, entry_action, entry_param, entry_track, in_range,
                         insert_status);
                mismatches++;
            end
            else
            begin
                response_t want;
                want = awaited_responses.pop_front();
                check_field("entry_action", 8'(want.action), 8'(entry_action));
                check_field("entry_param", want.param, entry_param);
                check_field("entry_track", want.track, entry_track);
                check_field("in_range", 8'(want.in_range), 8'(in_range));
                check_field("insert_status", 8'(want.status), 8'(insert_status));
            end
        end
    end

    // Watchdog: a long stretch with neither channel moving means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no request or response moved for %0d cycles",
                         $time, IDLE_LIMIT);
                $display("** coalescing_action_queue: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        request_t  r;
        response_t z;
        response_t w;
        int        episode;
        int        count;
        int        style;
        logic [TRACK_W-1:0] base;

        for (int i = 0; i < DEPTH; i++)
        begin
            slot_action[i] = NO_ACTION;
            slot_param[i]  = '0;
            slot_track[i]  = '0;
        end
        fill_count = 0;
        read_index = 0;
        z = '0;

        // Directed table. Rows with a hand-written response are the ones
        // whose answer is plain: reset contents, junk codes, status codes.
        w = z; w.in_range = 1'b1;
        add_row(REQ_READ,         NO_ACTION,  '0,        '0,        1'b1, w);
        add_row(REQ_UNUSED_LAST,  ACTION_MAX, PARAM_MAX, TRACK_MAX, 1'b1, z);
        add_row(REQ_ADVANCE,      NO_ACTION,  '0,        '0,        1'b1, w);
        add_row(REQ_READ,         ACTION_MAX, PARAM_MAX, TRACK_MAX, 1'b1, w);
        add_row(REQ_REWIND,       ACTION_MAX, PARAM_MAX, TRACK_MAX, 1'b1, z);
        w = z; w.status = ST_APPENDED;
        add_row(REQ_INSERT,       ACTION_MAX, PARAM_MAX, TRACK_MAX, 1'b1, w);
        // The no-action code is stored like any other action.
        add_row(REQ_INSERT,       NO_ACTION,  '0,        '0,        1'b1, w);
        w = z; w.status = ST_MERGED;
        add_row(REQ_INSERT,       ACTION_MAX, '0,        TRACK_MAX, 1'b1, w);
        add_row(REQ_INSERT,       NO_ACTION,  8'h5A,     '0,        1'b0, w);
        // Same action, other track: a new entry, not a merge.
        add_row(REQ_INSERT,       ACTION_MAX, 8'h11,     '0,        1'b0, z);
        w = z; w.action = ACTION_MAX; w.track = TRACK_MAX; w.in_range = 1'b1;
        add_row(REQ_READ,         NO_ACTION,  '0,        '0,        1'b1, w);
        w = z; w.in_range = 1'b1;
        add_row(REQ_ADVANCE,      NO_ACTION,  '0,        '0,        1'b1, w);
        add_row(REQ_READ,         NO_ACTION,  '0,        '0,        1'b0, z);
        add_row(REQ_UNUSED_FIRST, 3'b010,     8'h2A,     8'hD5,     1'b1, z);
        add_row(REQ_CLEAR,        ACTION_MAX, PARAM_MAX, TRACK_MAX, 1'b1, z);
        // After a clear the entry reads as no-action with its old fields.
        add_row(REQ_READ,         NO_ACTION,  '0,        '0,        1'b0, z);
        add_row(REQ_INSERT,       ACTION_MAX, 8'h33,     TRACK_MAX, 1'b0, z);
        add_row(REQ_READ,         NO_ACTION,  '0,        '0,        1'b0, z);
        add_row(REQ_CLEAR,        NO_ACTION,  '0,        '0,        1'b1, z);

        wait (rst_n);
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].req, directed_rows[i].known,
                         directed_rows[i].rsp);
        end

        // Random episodes. Most are well-formed: fill runs that merge and
        // overflow, and read walks that run the index into saturation.
        // The rest is junk with every field random.
        while (requests_sent < TOTAL_REQUESTS)
        begin
            quiet   = ($urandom_range(0, 4) == 0);
            episode = $urandom_range(0, 9);
            if (episode < 4)
            begin
                if ($urandom_range(0, 1))
                begin
                    r = request_t'($urandom);
                    r.kind = REQ_CLEAR;
                    send_request(r, 1'b0, z);
                end
                // Distinct tracks fill and overflow the table, a small track
                // pool produces many merges, fully random tracks sit between.
                count = $urandom_range(14, 20);
                style = $urandom_range(0, 2);
                base  = TRACK_W'($urandom);
                for (int k = 0; k < count; k++)
                begin
                    r = request_t'($urandom);
                    r.kind = REQ_INSERT;
                    if (style == 0)
                    begin
                        r.track = base + k[TRACK_W-1:0];
                    end
                    else if (style == 1)
                    begin
                        r.track = TRACK_W'($urandom_range(0, 3));
                        r.action = $urandom_range(0, 1) ? r.action : NO_ACTION;
                    end
                    send_request(r, 1'b0, z);
                end
            end
            else if (episode < 8)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    r = request_t'($urandom);
                    r.kind = REQ_REWIND;
                    send_request(r, 1'b0, z);
                end
                count = $urandom_range(4, DEPTH + 4);
                for (int k = 0; k < count; k++)
                begin
                    r = request_t'($urandom);
                    r.kind = REQ_READ;
                    send_request(r, 1'b0, z);
                    r = request_t'($urandom);
                    r.kind = REQ_ADVANCE;
                    send_request(r, 1'b0, z);
                end
            end
            else
            begin
                count = $urandom_range(6, 12);
                for (int k = 0; k < count; k++)
                begin
                    r = request_t'($urandom);
                    r.kind = REQ_W'($urandom_range(0, 7));
                    send_request(r, 1'b0, z);
                end
            end
        end
        req_valid <= 1'b0;
        quiet = 1'b0;

        // Drain, then keep watching for stray responses for TAIL_CYCLES longer.
        while (awaited_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("** coalescing_action_queue: PASSED **");
        end
        else
        begin
            $display("** coalescing_action_queue: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/caq_pkg.sv
src/caq_ram.sv
src/coalescing_action_queue.sv
sim/coalescing_action_queue_test.sv
